@@ hdl/wuf_pkg.sv @@
// Shared types, constants and helpers of the weighted union-find engine.
package wuf_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = IDX_W + 1;

  localparam logic OP_UNION = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] size;
    logic [IDX_W-1:0] parent;
  } node_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] value;
    logic [CNT_W-1:0] limit;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_elements(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = v;
    if (n == '0) begin
      n = CNT_W'(1);
    end
    if (n > CNT_W'(MAX_ELEMENTS)) begin
      n = CNT_W'(MAX_ELEMENTS);
    end
    return n;
  endfunction

endpackage

@@ hdl/wuf_seq.sv @@
// Node store and sequencer: clearing pass, root walks and union write-back.
module wuf_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wuf_pkg::cfg_t               cfg_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [wuf_pkg::IDX_W-1:0]   first_element_i,
  input  logic [wuf_pkg::IDX_W-1:0]   second_element_i,
  output logic                        done_o,
  output logic                        already_connected_o,
  output logic [wuf_pkg::CNT_W-1:0]   component_count_o,
  output logic                        status_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CLEAR    = 5'b00010,
    S_FIND     = 5'b00100,
    S_WR_SMALL = 5'b01000,
    S_WR_BIG   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  wuf_pkg::node_t mem_q [wuf_pkg::MAX_ELEMENTS];
  wuf_pkg::node_t rdata_q;

  logic                      we;
  logic [wuf_pkg::IDX_W-1:0] waddr;
  wuf_pkg::node_t            wdata;

  logic [wuf_pkg::IDX_W-1:0] clr_q, clr_d;
  logic [wuf_pkg::IDX_W-1:0] cur_q, cur_d;
  logic [wuf_pkg::IDX_W-1:0] second_q, second_d;
  logic [wuf_pkg::IDX_W-1:0] root_a_q, root_a_d;
  logic [wuf_pkg::CNT_W-1:0] size_a_q, size_a_d;
  logic [wuf_pkg::IDX_W-1:0] small_q, small_d;
  logic [wuf_pkg::IDX_W-1:0] big_q, big_d;
  logic [wuf_pkg::CNT_W-1:0] sum_q, sum_d;
  logic                      which_q, which_d;
  logic                      op_q, op_d;
  logic [wuf_pkg::CNT_W-1:0] count_q, count_d;
  logic                      done_q, done_d;
  logic                      ac_q, ac_d;
  logic                      status_q, status_d;
  logic                      oor;
  logic                      joined;

  assign oor = ({1'b0, first_element_i} >= cfg_i.limit) ||
               ({1'b0, second_element_i} >= cfg_i.limit);
  assign joined = (cur_q == root_a_q);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    second_d = second_q;
    root_a_d = root_a_q;
    size_a_d = size_a_q;
    small_d  = small_q;
    big_d    = big_q;
    sum_d    = sum_q;
    which_d  = which_q;
    op_d     = op_q;
    count_d  = count_q;
    done_d   = 1'b0;
    ac_d     = ac_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (oor) begin
            done_d   = 1'b1;
            ac_d     = 1'b0;
            status_d = wuf_pkg::STATUS_OOR;
          end else begin
            cur_d    = first_element_i;
            second_d = second_element_i;
            op_d     = op_i;
            which_d  = 1'b0;
            state_d  = S_FIND;
          end
        end
      end
      S_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_q;
        wdata.size   = wuf_pkg::CNT_W'(1);
        wdata.parent = clr_q;
        clr_d        = clr_q + wuf_pkg::IDX_W'(1);
        if (clr_q == wuf_pkg::IDX_W'(wuf_pkg::MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_FIND: begin
        if (rdata_q.parent == cur_q) begin
          if (!which_q) begin
            root_a_d = cur_q;
            size_a_d = rdata_q.size;
            which_d  = 1'b1;
            cur_d    = second_q;
          end else if (op_q == wuf_pkg::OP_UNION && !joined) begin
            // equal sizes keep the first root on top
            if (size_a_q < rdata_q.size) begin
              small_d = root_a_q;
              big_d   = cur_q;
            end else begin
              small_d = cur_q;
              big_d   = root_a_q;
            end
            sum_d   = size_a_q + rdata_q.size;
            state_d = S_WR_SMALL;
          end else begin
            done_d   = 1'b1;
            ac_d     = joined;
            status_d = wuf_pkg::STATUS_OK;
            state_d  = S_IDLE;
          end
        end else begin
          cur_d = rdata_q.parent;
        end
      end
      S_WR_SMALL: begin
        we           = 1'b1;
        waddr        = small_q;
        wdata.size   = sum_q;
        wdata.parent = big_q;
        state_d      = S_WR_BIG;
      end
      S_WR_BIG: begin
        we           = 1'b1;
        waddr        = big_q;
        wdata.size   = sum_q;
        wdata.parent = big_q;
        if (count_q != '0) begin
          count_d = count_q - wuf_pkg::CNT_W'(1);
        end
        done_d   = 1'b1;
        ac_d     = 1'b0;
        status_d = wuf_pkg::STATUS_OK;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.load) begin
      state_d = S_CLEAR;
      clr_d   = '0;
      count_d = cfg_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[cur_d];
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    second_q <= second_d;
    root_a_q <= root_a_d;
    size_a_q <= size_a_d;
    small_q  <= small_d;
    big_q    <= big_d;
    sum_q    <= sum_d;
    op_q     <= op_d;
    ac_q     <= ac_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      which_q <= 1'b0;
      count_q <= wuf_pkg::clamp_elements(wuf_pkg::CNT_W'(wuf_pkg::MAX_ELEMENTS));
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      which_q <= which_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  assign busy                = (state_q != S_IDLE);
  assign done_o              = done_q;
  assign already_connected_o = ac_q;
  assign component_count_o   = count_q;
  assign status_o            = status_q;

endmodule

@@ hdl/weighted_union_find_top.sv @@
// Top level of the weighted union-find engine: element count register and sequencer.
//
// Commands: an item (op_i, first_element_i, second_element_i) is taken at a
// clock edge with start high and busy low. op 0 joins the two sets, op 1 only
// asks whether they are joined. Each item gives exactly one result beat, shown
// for one cycle with done_o high, unless a count write cuts the item off; the
// receiver cannot hold it off. Flow: an out-of-range item answers in the cycle
// after it is taken and busy stays low. Otherwise the sequencer walks both
// parent chains, one node store read per cycle, writes the smaller root and then
// the bigger root back for a union that joins, and then gives the result beat. A
// tree of n elements is at most log2(n) deep: two separate trees reach depth 9
// each, one tree, which needs no write-back, depth 10.
// Configuration: cfg_we_i writes the element count (0 reads as 1, anything
// above 1024 as 1024) and re-initialises all sets. After reset and after every
// count write the node store is cleared one entry a cycle, all 1024 entries,
// with busy high; a count write during the clear restarts it.
// Reset: asynchronous, active low; the element count returns to 1024.
module weighted_union_find_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wuf_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [wuf_pkg::IDX_W-1:0]   first_element_i,
  input  logic [wuf_pkg::IDX_W-1:0]   second_element_i,
  output logic                        done_o,
  output logic                        already_connected_o,
  output logic [wuf_pkg::CNT_W-1:0]   component_count_o,
  output logic                        status_o
);

  logic [wuf_pkg::CNT_W-1:0] num_q, num_d;
  wuf_pkg::cfg_t             cfg;

  always_comb begin
    num_d = num_q;
    if (cfg_we_i) begin
      num_d = wuf_pkg::clamp_elements(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= wuf_pkg::clamp_elements(wuf_pkg::CNT_W'(wuf_pkg::MAX_ELEMENTS));
    end else begin
      num_q <= num_d;
    end
  end

  assign cfg.load  = cfg_we_i;
  assign cfg.value = wuf_pkg::clamp_elements(cfg_wdata_i);
  assign cfg.limit = num_q;

  wuf_seq u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .start               (start),
    .busy                (busy),
    .op_i                (op_i),
    .first_element_i     (first_element_i),
    .second_element_i    (second_element_i),
    .done_o              (done_o),
    .already_connected_o (already_connected_o),
    .component_count_o   (component_count_o),
    .status_o            (status_o)
  );

  a_cfg_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("count write did not start the clearing pass");

  a_oor_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i &&
     (({1'b0, first_element_i} >= num_q) || ({1'b0, second_element_i} >= num_q)))
    |=> (done_o && status_o == wuf_pkg::STATUS_OOR && !busy))
    else $error("out-of-range item not answered at once");

  a_oor_not_joined : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == wuf_pkg::STATUS_OOR) |-> !already_connected_o)
    else $error("out-of-range beat flags a connection");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (component_count_o <= num_q))
    else $error("component count above element count");

endmodule
